FILE: rtl/binomial_broadcast_peer_schedule_top_macros.svh
// Assertion macros for the broadcast peer schedule block.
`ifndef BINOMIAL_BROADCAST_PEER_SCHEDULE_TOP_MACROS_SVH
`define BINOMIAL_BROADCAST_PEER_SCHEDULE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle
`define BBPS_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("bbps assertion failed");
// Check that a condition implies another in the next cycle
`define BBPS_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("bbps assertion failed");
`else
`define BBPS_ASSERT_IMP(lbl, ck, rs, a, c)
`define BBPS_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

FILE: rtl/bbps_pkg.sv
// Shared types and constants of the broadcast peer schedule block.
package bbps_pkg;

  localparam int RANK_W = 10;
  localparam int CNT_W  = 11;
  localparam int DIR_W  = 2;

  // Direction codes of a schedule entry
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RECV = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SEND = 2'd2;

  // Configuration register indexes
  localparam logic CFG_NUM_RANKS = 1'b0;
  localparam logic CFG_MY_RANK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_PREP,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    K_RECV,
    K_ROOT,
    K_KID,
    K_PART,
    K_NONE
  } kind_t;

  // Result of one halving step of the path walk
  typedef struct packed {
    logic [RANK_W-1:0] nxt;
    logic              hit;
  } step_res_t;

endpackage

FILE: rtl/bbps_step.sv
// Shared compare and add/subtract unit: one halving step of the tree path walk.
module bbps_step (
  input  logic [bbps_pkg::RANK_W-1:0] cur,
  input  logic [bbps_pkg::RANK_W-1:0] target,
  input  logic [bbps_pkg::RANK_W-1:0] rs,
  output bbps_pkg::step_res_t         res
);
  import bbps_pkg::*;

  logic [RANK_W-1:0] mask;
  logic [RANK_W-1:0] tm;
  logic [RANK_W-1:0] cm;

  // Compare the parts above the step distance, then move one step
  always_comb begin
    mask = ~(rs - RANK_W'(1));
    tm   = target & mask;
    cm   = cur & mask;
    if (tm > cm) begin
      res.nxt = cur + rs;
    end else if (tm < cm) begin
      res.nxt = cur - rs;
    end else begin
      res.nxt = cur;
    end
    res.hit = (tm != cm) && (res.nxt == target);
  end

endmodule

FILE: rtl/bbps_map.sv
// Maps a tree rank back to a participant rank after pairwise folding.
module bbps_map (
  input  logic [bbps_pkg::RANK_W-1:0] tree_rank,
  input  logic [bbps_pkg::CNT_W-1:0]  extra,
  output logic [bbps_pkg::CNT_W-1:0]  rank
);
  import bbps_pkg::*;

  // Folded tree ranks sit on the odd member of their pair
  always_comb begin
    if ({1'b0, tree_rank} < extra) begin
      rank = {tree_rank, 1'b1};
    end else begin
      rank = {1'b0, tree_rank} + extra;
    end
  end

endmodule

FILE: rtl/binomial_broadcast_peer_schedule_top.sv
// Top level of the binomial broadcast peer schedule block.
//
// Each request carries a root rank and yields this node's schedule: the
// receive peer first, then the send peers (folded root partner, tree children
// by falling distance, folded partner), or one entry marked none. A request
// passes the set-up stages (power-of-two size, then fold mapping), then the
// halving steps of the path walk from the root to this node, all through
// one shared compare and add/subtract unit, then puts out its result entries
// one at a time while the output is not stalled. Walk steps plus entries
// never exceed log2 of the tree size plus two, which is 11 at most. An output
// stall holds the block in its emit phase. Input stall stays high from
// acceptance until the last entry is loaded into the output register, so no
// new request is taken before then.
`include "binomial_broadcast_peer_schedule_top_macros.svh"
module binomial_broadcast_peer_schedule_top #(
  parameter int MAX_RANKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [bbps_pkg::CNT_W-1:0]  wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bbps_pkg::RANK_W-1:0] root_rank,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bbps_pkg::RANK_W-1:0] peer_rank,
  output logic [bbps_pkg::DIR_W-1:0]  direction,
  output logic                        bad_root,
  output logic                        last
);
  import bbps_pkg::*;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [CNT_W-1:0]  num_ranks;
  logic [RANK_W-1:0] my_rank;

  // Per-request datapath
  logic [RANK_W-1:0] root;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  adj;
  logic [CNT_W-1:0]  extra;
  logic [RANK_W-1:0] me_new;
  logic [RANK_W-1:0] cur;
  logic [RANK_W-1:0] rs;
  logic              recv_pend;
  logic [CNT_W-1:0]  recv_rank;
  logic              root_pend;
  logic              part_pend;
  logic              bad;

  // Size stage logic
  logic [CNT_W-1:0] n_c;
  logic [CNT_W-1:0] adj_c;

  // Prep stage logic
  logic [CNT_W-1:0]  two_e;
  logic              me_ok;
  logic              bad_c;
  logic              me_fold;
  logic              me_even_f;
  logic              root_fold;
  logic              root_even_f;
  logic [RANK_W-1:0] me_new_c;
  logic [RANK_W-1:0] root_new_c;
  logic              walk_go;

  // Shared units
  step_res_t         step;
  logic [RANK_W-1:0] map_in;
  logic [CNT_W-1:0]  map_rank;

  // Emit logic
  logic              load;
  kind_t             kind;
  logic [RANK_W-1:0] e_peer;
  logic [DIR_W-1:0]  e_dir;
  logic              e_bad;
  logic              e_last;
  logic [RANK_W-1:0] rs_shift;
  logic              in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign rs_shift = rs >> 1;

  bbps_step u_step (
    .cur    (cur),
    .target (me_new),
    .rs     (rs),
    .res    (step)
  );

  // Share the map unit between the walk and the child entries
  assign map_in = (state == ST_WALK) ? cur : (me_new ^ rs);

  bbps_map u_map (
    .tree_rank (map_in),
    .extra     (extra),
    .rank      (map_rank)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_ranks <= CNT_W'(1);
      my_rank   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_NUM_RANKS: num_ranks <= wr_data;
        CFG_MY_RANK:   my_rank   <= wr_data[RANK_W-1:0];
        default:       num_ranks <= num_ranks;
      endcase
    end
  end

  // Clamp the rank count and find the largest power of two not above it
  always_comb begin
    if (num_ranks == '0) begin
      n_c = CNT_W'(1);
    end else if (32'(num_ranks) > 32'(MAX_RANKS)) begin
      n_c = CNT_W'(MAX_RANKS);
    end else begin
      n_c = num_ranks;
    end
    adj_c = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n_c[i]) begin
        adj_c = CNT_W'(1) << i;
      end
    end
  end

  // Fold this node and the root onto the tree
  always_comb begin
    two_e       = {extra[CNT_W-2:0], 1'b0};
    me_ok       = {1'b0, my_rank} < n_eff;
    bad_c       = {1'b0, root} >= n_eff;
    me_fold     = {1'b0, my_rank} < two_e;
    me_even_f   = me_fold && !my_rank[0];
    root_fold   = {1'b0, root} < two_e;
    root_even_f = root_fold && !root[0];
    me_new_c    = me_fold ? (my_rank >> 1) : RANK_W'({1'b0, my_rank} - extra);
    root_new_c  = root_fold ? (root >> 1) : RANK_W'({1'b0, root} - extra);
    walk_go     = me_ok && !bad_c && !me_even_f && (me_new_c != root_new_c);
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_SIZE;
      end
      ST_SIZE: state_next = ST_PREP;
      ST_PREP: state_next = walk_go ? ST_WALK : ST_EMIT;
      ST_WALK: begin
        if (step.nxt == me_new || rs_shift == '0) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && e_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pick the next schedule entry in output order
  always_comb begin
    in_stall = (state != ST_IDLE);
    load     = (state == ST_EMIT) && (!out_valid || !out_stall);
    e_bad    = 1'b0;
    priority if (recv_pend) begin
      kind   = K_RECV;
      e_peer = recv_rank[RANK_W-1:0];
      e_dir  = DIR_RECV;
      e_last = !(root_pend || (rs != '0) || part_pend);
    end else if (root_pend) begin
      kind   = K_ROOT;
      e_peer = root + RANK_W'(1);
      e_dir  = DIR_SEND;
      e_last = !((rs != '0) || part_pend);
    end else if (rs != '0) begin
      kind   = K_KID;
      e_peer = map_rank[RANK_W-1:0];
      e_dir  = DIR_SEND;
      e_last = !((rs_shift != '0) || part_pend);
    end else if (part_pend) begin
      kind   = K_PART;
      e_peer = my_rank - RANK_W'(1);
      e_dir  = DIR_SEND;
      e_last = 1'b1;
    end else begin
      kind   = K_NONE;
      e_peer = '0;
      e_dir  = DIR_NONE;
      e_bad  = bad;
      e_last = 1'b1;
    end
  end

  // Hold request control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      recv_pend <= 1'b0;
      root_pend <= 1'b0;
      part_pend <= 1'b0;
      rs        <= '0;
    end else begin
      unique case (state)
        ST_PREP: begin
          if (me_ok && !bad_c) begin
            recv_pend <= (root_even_f && ({1'b0, my_rank} == {1'b0, root} + CNT_W'(1)))
                         || (me_even_f && (my_rank != root));
            root_pend <= root_even_f && (my_rank == root);
            part_pend <= me_fold && !me_even_f && ((my_rank - RANK_W'(1)) != root);
            rs        <= me_even_f ? '0 : adj[CNT_W-1:1];
          end else begin
            recv_pend <= 1'b0;
            root_pend <= 1'b0;
            part_pend <= 1'b0;
            rs        <= '0;
          end
        end
        ST_WALK: begin
          rs <= rs_shift;
          if (step.hit) recv_pend <= 1'b1;
        end
        ST_EMIT: begin
          if (load) begin
            unique case (kind)
              K_RECV:  recv_pend <= 1'b0;
              K_ROOT:  root_pend <= 1'b0;
              K_KID:   rs        <= rs_shift;
              K_PART:  part_pend <= 1'b0;
              K_NONE:  part_pend <= 1'b0;
              default: part_pend <= 1'b0;
            endcase
          end
        end
        default: rs <= rs;
      endcase
    end
  end

  // Load request payload state
  always_ff @(posedge clk) begin
    if (in_acc) root <= root_rank;
    if (state == ST_SIZE) begin
      n_eff <= n_c;
      adj   <= adj_c;
      extra <= n_c - adj_c;
    end
    if (state == ST_PREP) begin
      me_new <= me_new_c;
      cur    <= root_new_c;
      bad    <= bad_c;
      if (root_even_f && ({1'b0, my_rank} == {1'b0, root} + CNT_W'(1))) begin
        recv_rank <= {1'b0, root};
      end else begin
        recv_rank <= {1'b0, my_rank} + CNT_W'(1);
      end
    end
    if (state == ST_WALK) begin
      cur <= step.nxt;
      if (step.hit) recv_rank <= map_rank;
    end
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      peer_rank <= e_peer;
      direction <= e_dir;
      bad_root  <= e_bad;
      last      <= e_last;
    end
  end

  `BBPS_ASSERT_IMP(a_none_is_last, clk, rst, out_valid && direction == DIR_NONE, last)
  `BBPS_ASSERT_IMP(a_bad_is_none, clk, rst, out_valid && bad_root, direction == DIR_NONE)
  `BBPS_ASSERT_NXT(a_busy_after_accept, clk, rst, in_acc, in_stall)
  `BBPS_ASSERT_IMP(a_walk_has_step, clk, rst, state == ST_WALK, rs != '0)

endmodule

FILE: tb/sv/binomial_broadcast_peer_schedule_top_test.sv
// Testbench for the binomial broadcast peer schedule block: table, random requests, self-check.
`timescale 1ns / 1ps

module binomial_broadcast_peer_schedule_top_test;
  import bbps_pkg::*;

  localparam int RANK_LIMIT   = 1024;
  localparam int RANDOM_ITEMS = 246;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_GAP      = 13;

  // One schedule entry as seen on the output port
  typedef struct packed {
    logic [RANK_W-1:0] peer;
    logic [DIR_W-1:0]  dir;
    logic              bad;
    logic              last;
  } sched_entry_t;

  // One directed request: register data, root, and an optional fixed answer
  typedef struct packed {
    logic [CNT_W-1:0]  ranks_data;
    logic [CNT_W-1:0]  self_data;
    logic [RANK_W-1:0] root;
    logic              fixed;
    sched_entry_t      answer;
  } probe_row_t;

  localparam sched_entry_t NO_PEERS = '{peer: '0, dir: DIR_NONE, bad: 1'b0, last: 1'b1};
  localparam sched_entry_t BAD_ROOT = '{peer: '0, dir: DIR_NONE, bad: 1'b1, last: 1'b1};
  localparam int PROBE_COUNT = 24;

  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    // reset setting: single rank
    '{11'd1,    11'd0,    10'd0,    1'b1, NO_PEERS},
    '{11'd1,    11'd0,    10'd1,    1'b1, BAD_ROOT},
    '{11'd1,    11'd0,    10'd1023, 1'b1, BAD_ROOT},
    // zero rank count acts as one
    '{11'd0,    11'd0,    10'd0,    1'b1, NO_PEERS},
    '{11'd0,    11'd0,    10'd1,    1'b1, BAD_ROOT},
    // rank count saturates at the maximum
    '{11'd2047, 11'd0,    10'd0,    1'b0, NO_PEERS},
    '{11'd2047, 11'd1023, 10'd0,    1'b0, NO_PEERS},
    '{11'd1024, 11'd1023, 10'd0,    1'b0, NO_PEERS},
    '{11'd1024, 11'd0,    10'd1023, 1'b0, NO_PEERS},
    '{11'd1025, 11'd5,    10'd1023, 1'b0, NO_PEERS},
    // own rank data with the top bit set is truncated
    '{11'd1024, 11'h7ff,  10'd512,  1'b0, NO_PEERS},
    // folded ranks: even root, even receiver, odd partner of root, odd root
    '{11'd1023, 11'd0,    10'd0,    1'b0, NO_PEERS},
    '{11'd1023, 11'd0,    10'd6,    1'b0, NO_PEERS},
    '{11'd1023, 11'd1,    10'd0,    1'b0, NO_PEERS},
    '{11'd1023, 11'd1,    10'd1,    1'b0, NO_PEERS},
    '{11'd1023, 11'd1022, 10'd1022, 1'b0, NO_PEERS},
    // own rank out of range
    '{11'd5,    11'd7,    10'd0,    1'b1, NO_PEERS},
    '{11'd5,    11'd1023, 10'd1023, 1'b1, BAD_ROOT},
    '{11'd5,    11'd5,    10'd0,    1'b1, NO_PEERS},
    // small sizes
    '{11'd5,    11'd1,    10'd3,    1'b0, NO_PEERS},
    '{11'd3,    11'd2,    10'd2,    1'b0, NO_PEERS},
    '{11'd2,    11'd1,    10'd0,    1'b0, NO_PEERS},
    '{11'd2,    11'd0,    10'd1,    1'b0, NO_PEERS},
    '{11'd6,    11'd3,    10'd4,    1'b0, NO_PEERS}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en = 1'b0;
  logic              wr_index = CFG_NUM_RANKS;
  logic [CNT_W-1:0]  wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [RANK_W-1:0] root_rank = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RANK_W-1:0] peer_rank;
  logic [DIR_W-1:0]  direction;
  logic              bad_root;
  logic              last;

  // Shadow copy of the configuration registers
  logic [CNT_W-1:0]  ranks_reg = 11'd1;
  logic [RANK_W-1:0] self_reg = '0;

  sched_entry_t sched_q [$];
  int           mismatches = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           quiet = 1'b0;

  binomial_broadcast_peer_schedule_top #(
    .MAX_RANKS(RANK_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .root_rank(root_rank),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .peer_rank(peer_rank),
    .direction(direction),
    .bad_root (bad_root),
    .last     (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries pending", cycles, sched_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Map a tree position back to a rank
  function automatic int unsigned tree_to_rank(input int unsigned pos, input int unsigned spare);
    return (pos < spare) ? (pos * 2 + 1) : (pos + spare);
  endfunction

  // Work out this node's schedule for one root and queue the entries
  function automatic void plan_schedule(input logic [RANK_W-1:0] root);
    int unsigned n, me, r, span, spare, me_t, root_t, reach, cur, hop, recv;
    int unsigned sends [$];
    bit has_recv, found, me_lean, bad;
    n = 32'(ranks_reg);
    me = 32'(self_reg);
    r = 32'(root);
    has_recv = 1'b0;
    recv = 0;
    if (n == 0) n = 1;
    if (n > RANK_LIMIT) n = RANK_LIMIT;
    bad = (r >= n);
    if (!bad && me < n) begin
      span = 1;
      while (span <= n) span <<= 1;
      span >>= 1;
      spare = n - span;
      me_lean = (me < 2 * spare) && ((me & 1) == 0);
      me_t = (me < 2 * spare) ? (me >> 1) : (me - spare);
      // fold the root: an even folded root hands off to its odd partner
      if (r < 2 * spare) begin
        if ((r & 1) == 0) begin
          if (me == r) sends.push_back(r + 1);
          if (me == r + 1) begin
            has_recv = 1'b1;
            recv = r;
          end
        end
        root_t = r >> 1;
      end else begin
        root_t = r - spare;
      end
      reach = span >> 1;
      if (me_lean) begin
        if (me != r) begin
          has_recv = 1'b1;
          recv = me + 1;
        end
        reach = 0;
      end else if (me_t != root_t) begin
        // walk the halving path from the root down to this node
        cur = root_t;
        found = 1'b0;
        hop = 0;
        while (cur != me_t && reach > 0) begin
          if (me_t / reach > cur / reach) begin
            if (cur + reach == me_t) begin
              hop = cur;
              found = 1'b1;
            end
            cur += reach;
          end else if (me_t / reach < cur / reach) begin
            if (cur - reach == me_t) begin
              hop = cur;
              found = 1'b1;
            end
            cur -= reach;
          end
          reach >>= 1;
        end
        if (found) begin
          has_recv = 1'b1;
          recv = tree_to_rank(hop, spare);
        end
      end
      // children by falling distance below the meeting point
      while (reach > 0 && sends.size() < 14) begin
        sends.push_back(tree_to_rank(me_t ^ reach, spare));
        reach >>= 1;
      end
      if (!me_lean && me_t < spare && me >= 1 && (me - 1) != r)
        sends.push_back(me - 1);
    end
    if (!has_recv && sends.size() == 0) begin
      sched_q.push_back({RANK_W'(0), DIR_NONE, bad, 1'b1});
    end else begin
      if (has_recv)
        sched_q.push_back({RANK_W'(recv), DIR_RECV, 1'b0, sends.size() == 0});
      foreach (sends[i])
        sched_q.push_back({RANK_W'(sends[i]), DIR_SEND, 1'b0, i == sends.size() - 1});
    end
  endfunction

  // Stall the output at random and check each accepted entry
  always @(posedge clk) begin
    sched_entry_t want;
    if (rst) begin
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          report_mismatch("unexpected entry, peer", int'(peer_rank), -1);
        end else begin
          want = sched_q.pop_front();
          if (peer_rank !== want.peer)
            report_mismatch("peer_rank", int'(peer_rank), int'(want.peer));
          if (direction !== want.dir)
            report_mismatch("direction", int'(direction), int'(want.dir));
          if (bad_root !== want.bad)
            report_mismatch("bad_root", int'(bad_root), int'(want.bad));
          if (last !== want.last)
            report_mismatch("last", int'(last), int'(want.last));
        end
        stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (stall_left > 0);
  end

  // Drop valid and wait until every queued entry has come out
  task automatic drain_schedule();
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on consecutive edges
  task automatic configure(input logic [CNT_W-1:0] ranks_data,
                           input logic [CNT_W-1:0] self_data);
    wr_en <= 1'b1;
    wr_index <= CFG_NUM_RANKS;
    wr_data <= ranks_data;
    @(posedge clk);
    wr_index <= CFG_MY_RANK;
    wr_data <= self_data;
    @(posedge clk);
    wr_en <= 1'b0;
    ranks_reg = ranks_data;
    self_reg = self_data[RANK_W-1:0];
  endtask

  // Present one request, hold it until taken, then idle for the drawn gap
  task automatic send_root(input logic [RANK_W-1:0] root);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    in_valid <= 1'b1;
    root_rank <= root;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [CNT_W-1:0]  ranks_data, self_data;
    logic [RANK_W-1:0] root;
    int unsigned eff, run_len, sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; reconfigure only when the row asks for it
    foreach (PROBES[i]) begin
      if (PROBES[i].ranks_data != ranks_reg || PROBES[i].self_data[RANK_W-1:0] != self_reg ||
          PROBES[i].self_data[CNT_W-1] != 1'b0) begin
        drain_schedule();
        configure(PROBES[i].ranks_data, PROBES[i].self_data);
      end
      if (PROBES[i].fixed)
        sched_q.push_back(PROBES[i].answer);
      else
        plan_schedule(PROBES[i].root);
      send_root(PROBES[i].root);
    end

    // Random phases, each with its own setting and idling mode
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_schedule();
      case ($urandom_range(0, 9))
        0: ranks_data = $urandom_range(0, 1) ? 11'd0 : CNT_W'($urandom_range(1025, 2047));
        1: ranks_data = 11'd1024;
        2, 3, 4, 5: ranks_data = CNT_W'($urandom_range(1, 40));
        default: ranks_data = CNT_W'($urandom_range(1, 1024));
      endcase
      eff = (ranks_data == '0) ? 1 :
            (32'(ranks_data) > RANK_LIMIT) ? RANK_LIMIT : 32'(ranks_data);
      if ($urandom_range(0, 7) == 0)
        self_data = CNT_W'($urandom_range(0, 2047));
      else
        self_data = CNT_W'($urandom_range(0, eff - 1));
      configure(ranks_data, self_data);
      quiet = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(8, 30);
      repeat (run_len) begin
        case ($urandom_range(0, 9))
          0: root = RANK_W'($urandom_range(0, 1023));
          1: root = self_reg;
          default: root = RANK_W'($urandom_range(0, eff - 1));
        endcase
        plan_schedule(root);
        send_root(root);
        sent++;
      end
    end

    // Let the last schedule come out, then look for strays
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
